/* hdl/rmcv_pkg.sv */
package rmcv_pkg;

   // built maximum of the matrix dimension
   localparam int MAX_N_DEFAULT = 64;
   // longest run that the result index can carry
   localparam int RES_LIMIT = 64;
   localparam int FRAC_BITS = 24;

   localparam int IDX_W = 6;
   localparam int SIZE_W = 7;
   localparam int VAL_W = 32;
   localparam int ACC_W = 64;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 32;

   // request codes
   localparam logic [1:0] FUNC_MAT_WR = 2'd0;
   localparam logic [1:0] FUNC_VEC_WR = 2'd1;
   localparam logic [1:0] FUNC_RUN    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_IN_USE    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE_MODE = 4'd1;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // control that travels alongside one matrix-vector term
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             endk;
      logic             endrow;
      logic [IDX_W-1:0] idx;
   } rmcv_tag_type;

endpackage

/* hdl/rmcv_ram.sv */
module rmcv_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rmcv_sequencer.sv */
module rmcv_sequencer #(
   parameter int MAX_N   = rmcv_pkg::MAX_N_DEFAULT,
   parameter int ADDR_W  = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1,
   parameter int VADDR_W = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start_run,
   input  logic [rmcv_pkg::SIZE_W-1:0] size_in_use,
   input  logic                        transpose_mode,
   output logic                        running,
   output rmcv_pkg::rmcv_tag_type      tag,
   output logic [ADDR_W-1:0]           mat_rd_addr,
   output logic [VADDR_W-1:0]          vec_rd_addr
);

   localparam int N_LIMIT = (MAX_N < rmcv_pkg::RES_LIMIT) ? MAX_N : rmcv_pkg::RES_LIMIT;

   rmcv_pkg::seq_state_type state_ff, state_in;
   logic [rmcv_pkg::IDX_W-1:0] i_ff, i_in;
   logic [rmcv_pkg::IDX_W-1:0] k_ff, k_in;
   logic [rmcv_pkg::IDX_W-1:0] n_m1_ff, n_m1_in;
   logic [rmcv_pkg::SIZE_W-1:0] n_eff;
   logic endk, endrow;

   // size 0 acts as 1, oversize clips to the built limit
   always_comb begin
      n_eff = size_in_use;
      if (size_in_use == '0) begin
         n_eff = rmcv_pkg::SIZE_W'(1);
      end else if (size_in_use > rmcv_pkg::SIZE_W'(N_LIMIT)) begin
         n_eff = rmcv_pkg::SIZE_W'(N_LIMIT);
      end
   end

   assign endk   = (k_ff == n_m1_ff);
   assign endrow = (i_ff == n_m1_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmcv_pkg::SEQ_IDLE: begin
            if (start_run) begin
               state_in = rmcv_pkg::SEQ_RUN;
            end
         end
         rmcv_pkg::SEQ_RUN: begin
            if (endk && endrow) begin
               state_in = rmcv_pkg::SEQ_IDLE;
            end
         end
         default: state_in = rmcv_pkg::SEQ_IDLE;
      endcase
   end

   // counters and issue outputs
   always_comb begin
      i_in        = i_ff;
      k_in        = k_ff;
      n_m1_in     = n_m1_ff;
      running     = 1'b0;
      tag         = '0;
      case (state_ff)
         rmcv_pkg::SEQ_IDLE: begin
            if (start_run) begin
               i_in    = '0;
               k_in    = '0;
               n_m1_in = rmcv_pkg::IDX_W'(n_eff - rmcv_pkg::SIZE_W'(1));
            end
         end
         rmcv_pkg::SEQ_RUN: begin
            running    = 1'b1;
            tag.valid  = 1'b1;
            tag.first  = (k_ff == '0);
            tag.endk   = endk;
            tag.endrow = endrow;
            tag.idx    = i_ff;
            if (endk) begin
               k_in = '0;
               i_in = i_ff + rmcv_pkg::IDX_W'(1);
            end else begin
               k_in = k_ff + rmcv_pkg::IDX_W'(1);
            end
         end
         default: running = 1'b0;
      endcase
   end

   assign mat_rd_addr = transpose_mode ? ADDR_W'(int'(k_ff) * MAX_N + int'(i_ff))
                                       : ADDR_W'(int'(i_ff) * MAX_N + int'(k_ff));
   assign vec_rd_addr = VADDR_W'(k_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmcv_pkg::SEQ_IDLE;
         i_ff     <= '0;
         k_ff     <= '0;
         n_m1_ff  <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         n_m1_ff  <= n_m1_in;
      end
   end

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmcv_pkg::SEQ_RUN) |-> (k_ff <= n_m1_ff && i_ff <= n_m1_ff))
      else $error("walk index beyond run size");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (tag.valid && tag.endk && tag.endrow) |=> (state_ff == rmcv_pkg::SEQ_IDLE))
      else $error("walk did not stop after final term");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (tag.valid && tag.endk && !tag.endrow) |=> (tag.valid && tag.first))
      else $error("next row did not start at column zero");

endmodule

/* hdl/rmcv_mac.sv */
module rmcv_mac (
   input  logic                             clock,
   input  logic                             reset,
   input  rmcv_pkg::rmcv_tag_type           tag,
   input  logic signed [rmcv_pkg::VAL_W-1:0] mat_q,
   input  logic signed [rmcv_pkg::VAL_W-1:0] vre_q,
   input  logic signed [rmcv_pkg::VAL_W-1:0] vim_q,
   output logic                             busy,
   output logic                             rsp_valid,
   output logic [rmcv_pkg::IDX_W-1:0]       rsp_index,
   output logic signed [rmcv_pkg::ACC_W-1:0] rsp_re,
   output logic signed [rmcv_pkg::ACC_W-1:0] rsp_im,
   output logic                             rsp_last
);

   localparam int PROD_W = 2 * rmcv_pkg::VAL_W;

   rmcv_pkg::rmcv_tag_type tag1_ff, tag2_ff;
   logic signed [PROD_W-1:0] prod_re_ff, prod_im_ff;
   logic signed [rmcv_pkg::ACC_W-1:0] acc_re_ff, acc_re_in;
   logic signed [rmcv_pkg::ACC_W-1:0] acc_im_ff, acc_im_in;
   logic rsp_valid_ff;
   logic [rmcv_pkg::IDX_W-1:0] rsp_index_ff;
   logic signed [rmcv_pkg::ACC_W-1:0] rsp_re_ff, rsp_im_ff;
   logic rsp_last_ff;

   // floor rescale, then a saturating add onto the running sum
   function automatic logic signed [rmcv_pkg::ACC_W-1:0] sat_acc(
      input logic signed [rmcv_pkg::ACC_W-1:0] base,
      input logic signed [PROD_W-1:0]          prod
   );
      logic signed [rmcv_pkg::ACC_W-1:0] term;
      logic [rmcv_pkg::ACC_W:0] sum;
      logic signed [rmcv_pkg::ACC_W-1:0] res;
      term = rmcv_pkg::ACC_W'(prod >>> rmcv_pkg::FRAC_BITS);
      sum  = {base[rmcv_pkg::ACC_W-1], base} + {term[rmcv_pkg::ACC_W-1], term};
      res  = sum[rmcv_pkg::ACC_W-1:0];
      if (sum[rmcv_pkg::ACC_W] != sum[rmcv_pkg::ACC_W-1]) begin
         res = sum[rmcv_pkg::ACC_W] ? {1'b1, {(rmcv_pkg::ACC_W-1){1'b0}}}
                                    : {1'b0, {(rmcv_pkg::ACC_W-1){1'b1}}};
      end
      return res;
   endfunction

   always_comb begin
      acc_re_in = sat_acc(tag2_ff.first ? '0 : acc_re_ff, prod_re_ff);
      acc_im_in = sat_acc(tag2_ff.first ? '0 : acc_im_ff, prod_im_ff);
   end

   // tag pipe follows read then multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag1_ff      <= tag;
         tag2_ff      <= tag1_ff;
         rsp_valid_ff <= tag2_ff.valid && tag2_ff.endk;
      end
   end

   always_ff @(posedge clock) begin
      prod_re_ff <= PROD_W'(mat_q) * PROD_W'(vre_q);
      prod_im_ff <= PROD_W'(mat_q) * PROD_W'(vim_q);
      if (tag2_ff.valid) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
      if (tag2_ff.valid && tag2_ff.endk) begin
         rsp_index_ff <= tag2_ff.idx;
         rsp_re_ff    <= acc_re_in;
         rsp_im_ff    <= acc_im_in;
         rsp_last_ff  <= tag2_ff.endrow;
      end
   end

   assign busy      = tag1_ff.valid || tag2_ff.valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_re    = rsp_re_ff;
   assign rsp_im    = rsp_im_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

/* hdl/real_matrix_complex_vector_multiply.sv */
// channel   direction  handshake              payload
// req       in         start, busy            func, row, col, mat_value, vec_re, vec_im
// rsp       out        rsp_valid (strobe)     out_index, out_re, out_im, last
// csr       in         csr_valid, csr_ready   csr_index, csr_wdata
//
// a load word is written into the memory at the accepting edge
// a run walks the matrix one term per cycle from the matrix memory read port, through
// the read, multiply and accumulate registers
// a result strobes once per row during the run, the last one ends the run
// reset clears control only; the stores hold nothing until written, no clearing pass
// results cannot be held off: each is valid for exactly one cycle
module real_matrix_complex_vector_multiply #(
   parameter int MAX_N = rmcv_pkg::MAX_N_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_func,
   input  logic [rmcv_pkg::IDX_W-1:0]           req_row,
   input  logic [rmcv_pkg::IDX_W-1:0]           req_col,
   input  logic signed [rmcv_pkg::VAL_W-1:0]    req_mat_value,
   input  logic signed [rmcv_pkg::VAL_W-1:0]    req_vec_re,
   input  logic signed [rmcv_pkg::VAL_W-1:0]    req_vec_im,
   // result channel
   output logic                                 rsp_valid,
   output logic [rmcv_pkg::IDX_W-1:0]           rsp_out_index,
   output logic signed [rmcv_pkg::ACC_W-1:0]    rsp_out_re,
   output logic signed [rmcv_pkg::ACC_W-1:0]    rsp_out_im,
   output logic                                 rsp_last,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rmcv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rmcv_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int MAT_DEPTH = MAX_N * MAX_N;
   localparam int ADDR_W    = (MAX_N > 1) ? $clog2(MAT_DEPTH) : 1;
   localparam int VADDR_W   = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int VW        = rmcv_pkg::VAL_W;

   logic req_take;
   logic run_start;
   logic mat_we, vec_we;
   logic [ADDR_W-1:0] mat_wr_addr, mat_rd_addr;
   logic [VADDR_W-1:0] vec_wr_addr, vec_rd_addr;
   logic [VW-1:0] mat_q;
   logic [2*VW-1:0] vec_q;
   logic seq_running, mac_busy;
   rmcv_pkg::rmcv_tag_type issue_tag;

   // configuration registers
   logic [rmcv_pkg::SIZE_W-1:0] size_in_use_ff;
   logic                        transpose_mode_ff;

   // csr writes always land at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_in_use_ff    <= rmcv_pkg::SIZE_W'(64);
         transpose_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rmcv_pkg::CSR_SIZE_IN_USE:    size_in_use_ff <= csr_wdata[rmcv_pkg::SIZE_W-1:0];
            rmcv_pkg::CSR_TRANSPOSE_MODE: transpose_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // busy spans the walk and the drain of the term pipe
   assign busy     = seq_running || mac_busy;
   assign req_take = start && !busy;

   // loads outside the built store are dropped
   assign mat_we = req_take && (req_func == rmcv_pkg::FUNC_MAT_WR)
                   && (int'(req_row) < MAX_N) && (int'(req_col) < MAX_N);
   assign vec_we = req_take && (req_func == rmcv_pkg::FUNC_VEC_WR)
                   && (int'(req_row) < MAX_N);
   assign run_start = req_take && (req_func == rmcv_pkg::FUNC_RUN);

   assign mat_wr_addr = ADDR_W'(int'(req_row) * MAX_N + int'(req_col));
   assign vec_wr_addr = VADDR_W'(req_row);

   // matrix store, row-major at row*MAX_N+col
   rmcv_ram #(
      .DEPTH (MAT_DEPTH),
      .WIDTH (VW),
      .AW    (ADDR_W)
   ) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_wr_addr),
      .wr_data (req_mat_value),
      .rd_addr (mat_rd_addr),
      .rd_data (mat_q)
   );

   // vector store, real part in the upper half
   rmcv_ram #(
      .DEPTH (MAX_N),
      .WIDTH (2 * VW),
      .AW    (VADDR_W)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (vec_wr_addr),
      .wr_data ({req_vec_re, req_vec_im}),
      .rd_addr (vec_rd_addr),
      .rd_data (vec_q)
   );

   // walks rows and columns, one term issued per cycle
   rmcv_sequencer #(
      .MAX_N   (MAX_N),
      .ADDR_W  (ADDR_W),
      .VADDR_W (VADDR_W)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start_run      (run_start),
      .size_in_use    (size_in_use_ff),
      .transpose_mode (transpose_mode_ff),
      .running        (seq_running),
      .tag            (issue_tag),
      .mat_rd_addr    (mat_rd_addr),
      .vec_rd_addr    (vec_rd_addr)
   );

   // multiply, rescale and accumulate, one row sum per result
   rmcv_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .tag       (issue_tag),
      .mat_q     (mat_q),
      .vre_q     (vec_q[2*VW-1:VW]),
      .vim_q     (vec_q[VW-1:0]),
      .busy      (mac_busy),
      .rsp_valid (rsp_valid),
      .rsp_index (rsp_out_index),
      .rsp_re    (rsp_out_re),
      .rsp_im    (rsp_out_im),
      .rsp_last  (rsp_last)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

   localparam int DIM = rmcv_pkg::MAX_N_DEFAULT;
   // unused request code, must be swallowed without a result
   localparam logic [1:0] FUNC_NOP = 2'd3;
   // register index with nothing behind it
   localparam logic [rmcv_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 4'd15;
   // far beyond any honest gap between handshakes, even in a 64x64 run
   localparam int STALL_LIMIT = 2000;
   // a load word leaves no result behind, give it time to land
   localparam int SETTLE_CYCLES = 8;
   localparam int RESET_CYCLES = 7;
   // largest random run size, keeps the loads of a full fill few
   localparam int MAX_RAND_SIZE = 8;

   // one request word
   typedef struct {
      logic [1:0]                        func;
      logic [rmcv_pkg::IDX_W-1:0]        row;
      logic [rmcv_pkg::IDX_W-1:0]        col;
      logic signed [rmcv_pkg::VAL_W-1:0] mat_value;
      logic signed [rmcv_pkg::VAL_W-1:0] vec_re;
      logic signed [rmcv_pkg::VAL_W-1:0] vec_im;
   } mvm_cmd_type;

   // one expected output element of a run
   typedef struct {
      logic [rmcv_pkg::IDX_W-1:0]        index;
      logic signed [rmcv_pkg::ACC_W-1:0] re;
      logic signed [rmcv_pkg::ACC_W-1:0] im;
      logic                              last;
   } row_sum_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              start = 1'b0;
   logic                              busy;
   logic [1:0]                        req_func = rmcv_pkg::FUNC_MAT_WR;
   logic [rmcv_pkg::IDX_W-1:0]        req_row = '0;
   logic [rmcv_pkg::IDX_W-1:0]        req_col = '0;
   logic signed [rmcv_pkg::VAL_W-1:0] req_mat_value = '0;
   logic signed [rmcv_pkg::VAL_W-1:0] req_vec_re = '0;
   logic signed [rmcv_pkg::VAL_W-1:0] req_vec_im = '0;

   logic                              rsp_valid;
   logic [rmcv_pkg::IDX_W-1:0]        rsp_out_index;
   logic signed [rmcv_pkg::ACC_W-1:0] rsp_out_re;
   logic signed [rmcv_pkg::ACC_W-1:0] rsp_out_im;
   logic                              rsp_last;

   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [rmcv_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [rmcv_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   // shadow of the block: stores and registers as seen by accepted words
   logic signed [rmcv_pkg::VAL_W-1:0] mat_shadow [DIM][DIM];
   logic signed [rmcv_pkg::VAL_W-1:0] vre_shadow [DIM];
   logic signed [rmcv_pkg::VAL_W-1:0] vim_shadow [DIM];
   logic [rmcv_pkg::SIZE_W-1:0]       size_shadow = 7'd64;
   logic                              transpose_shadow = 1'b0;

   // generator side: which entries have a load queued, so runs never read garbage
   bit mat_loaded [DIM][DIM];
   bit vec_loaded [DIM];
   int gen_size = DIM;

   mvm_cmd_type cmd_queue [$];
   row_sum_type row_sum_queue [$];
   int queued_count = 0;
   int accepted_count = 0;
   int fail_count = 0;
   int send_idle_pct = 0;
   int stall_cycles = 0;

   real_matrix_complex_vector_multiply uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_mat_value (req_mat_value),
      .req_vec_re    (req_vec_re),
      .req_vec_im    (req_vec_im),
      .rsp_valid     (rsp_valid),
      .rsp_out_index (rsp_out_index),
      .rsp_out_re    (rsp_out_re),
      .rsp_out_im    (rsp_out_im),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // size register to the dimension a run really uses: zero acts as one,
   // anything past the stores acts as the full size
   function automatic int active_size(input logic [rmcv_pkg::SIZE_W-1:0] reg_value);
      if (reg_value == 0)
         return 1;
      if (reg_value > DIM)
         return DIM;
      return int'(reg_value);
   endfunction

   // accumulate with clamping to the signed 64-bit range
   function automatic logic signed [rmcv_pkg::ACC_W-1:0] sat_add(
      input logic signed [rmcv_pkg::ACC_W-1:0] a,
      input logic signed [rmcv_pkg::ACC_W-1:0] b
   );
      logic [rmcv_pkg::ACC_W:0] sum;
      sum = {a[rmcv_pkg::ACC_W-1], a} + {b[rmcv_pkg::ACC_W-1], b};
      if (sum[rmcv_pkg::ACC_W] != sum[rmcv_pkg::ACC_W-1])
         return sum[rmcv_pkg::ACC_W] ? {1'b1, {(rmcv_pkg::ACC_W-1){1'b0}}}
                                     : {1'b0, {(rmcv_pkg::ACC_W-1){1'b1}}};
      return sum[rmcv_pkg::ACC_W-1:0];
   endfunction

   // expected output elements of one run, from the shadow stores
   task automatic predict_rows();
      int n;
      logic signed [rmcv_pkg::ACC_W-1:0] acc_re;
      logic signed [rmcv_pkg::ACC_W-1:0] acc_im;
      logic signed [rmcv_pkg::ACC_W-1:0] m;
      logic signed [rmcv_pkg::ACC_W-1:0] vr;
      logic signed [rmcv_pkg::ACC_W-1:0] vi;
      logic signed [rmcv_pkg::ACC_W-1:0] prod;
      row_sum_type word;
      n = active_size(size_shadow);
      for (int i = 0; i < n; i++) begin
         acc_re = '0;
         acc_im = '0;
         for (int k = 0; k < n; k++) begin
            // transpose walks a column instead of a row
            m = transpose_shadow ? mat_shadow[k][i] : mat_shadow[i][k];
            vr = vre_shadow[k];
            vi = vim_shadow[k];
            // exact 64-bit product, then floor shift back to 24 fraction bits
            prod = m * vr;
            acc_re = sat_add(acc_re, prod >>> rmcv_pkg::FRAC_BITS);
            prod = m * vi;
            acc_im = sat_add(acc_im, prod >>> rmcv_pkg::FRAC_BITS);
         end
         word.index = i[rmcv_pkg::IDX_W-1:0];
         word.re = acc_re;
         word.im = acc_im;
         word.last = (i == n - 1);
         row_sum_queue.push_back(word);
      end
   endtask

   // --------------------------------------------------------------------
   // driver: holds a word while busy, picks the next one once it is taken
   // --------------------------------------------------------------------
   always @(posedge clock) begin : driver
      mvm_cmd_type cmd;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         // nothing pending or the pending word was just taken
         if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cmd = cmd_queue.pop_front();
            start <= 1'b1;
            req_func <= cmd.func;
            req_row <= cmd.row;
            req_col <= cmd.col;
            req_mat_value <= cmd.mat_value;
            req_vec_re <= cmd.vec_re;
            req_vec_im <= cmd.vec_im;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------
   // monitor: checks result words, feeds the shadow with accepted words
   // --------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      row_sum_type want;
      if (reset) begin
         size_shadow = 7'd64;
         transpose_shadow = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (row_sum_queue.size() == 0) begin
               $error("unexpected result word, out_index %0d", rsp_out_index);
               fail_count++;
            end else begin
               want = row_sum_queue.pop_front();
               if (rsp_out_index !== want.index) begin
                  $error("out_index expected %0d actual %0d", want.index, rsp_out_index);
                  fail_count++;
               end
               if (rsp_out_re !== want.re) begin
                  $error("out_re expected %0d actual %0d", want.re, rsp_out_re);
                  fail_count++;
               end
               if (rsp_out_im !== want.im) begin
                  $error("out_im expected %0d actual %0d", want.im, rsp_out_im);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rmcv_pkg::CSR_SIZE_IN_USE: begin
                  size_shadow = csr_wdata[rmcv_pkg::SIZE_W-1:0];
               end
               rmcv_pkg::CSR_TRANSPOSE_MODE: begin
                  transpose_shadow = csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (start && !busy) begin
            accepted_count <= accepted_count + 1;
            case (req_func)
               rmcv_pkg::FUNC_MAT_WR: begin
                  mat_shadow[req_row][req_col] = req_mat_value;
               end
               rmcv_pkg::FUNC_VEC_WR: begin
                  vre_shadow[req_row] = req_vec_re;
                  vim_shadow[req_row] = req_vec_im;
               end
               rmcv_pkg::FUNC_RUN: begin
                  predict_rows();
               end
               default: begin
               end
            endcase
         end
      end
   end

   // --------------------------------------------------------------------
   // watchdog: any handshake on any channel counts as progress
   // --------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // --------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------

   // q8.24 value, biased toward the corners
   function automatic logic [rmcv_pkg::VAL_W-1:0] pick_q824();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'h0100_0000;
         4: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // fields a word does not use still get random bits
   function automatic mvm_cmd_type random_cmd();
      mvm_cmd_type c;
      c.func = 2'($urandom_range(3));
      c.row = rmcv_pkg::IDX_W'($urandom_range(DIM - 1));
      c.col = rmcv_pkg::IDX_W'($urandom_range(DIM - 1));
      c.mat_value = $urandom;
      c.vec_re = $urandom;
      c.vec_im = $urandom;
      return c;
   endfunction

   task automatic push_cmd(input mvm_cmd_type c);
      if (c.func == rmcv_pkg::FUNC_MAT_WR)
         mat_loaded[c.row][c.col] = 1'b1;
      if (c.func == rmcv_pkg::FUNC_VEC_WR)
         vec_loaded[c.row] = 1'b1;
      cmd_queue.push_back(c);
      queued_count++;
   endtask

   task automatic put_matrix(input int r, input int c,
                             input logic [rmcv_pkg::VAL_W-1:0] value);
      mvm_cmd_type cmd;
      cmd = random_cmd();
      cmd.func = rmcv_pkg::FUNC_MAT_WR;
      cmd.row = r[rmcv_pkg::IDX_W-1:0];
      cmd.col = c[rmcv_pkg::IDX_W-1:0];
      cmd.mat_value = value;
      push_cmd(cmd);
   endtask

   task automatic put_vector(input int r, input logic [rmcv_pkg::VAL_W-1:0] re,
                             input logic [rmcv_pkg::VAL_W-1:0] im);
      mvm_cmd_type cmd;
      cmd = random_cmd();
      cmd.func = rmcv_pkg::FUNC_VEC_WR;
      cmd.row = r[rmcv_pkg::IDX_W-1:0];
      cmd.vec_re = re;
      cmd.vec_im = im;
      push_cmd(cmd);
   endtask

   task automatic put_func(input logic [1:0] func);
      mvm_cmd_type cmd;
      cmd = random_cmd();
      cmd.func = func;
      push_cmd(cmd);
   endtask

   // load every entry a run of size n reads that has no load yet
   task automatic fill_missing(input int n);
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            if (!mat_loaded[r][c])
               put_matrix(r, c, pick_q824());
         end
         if (!vec_loaded[r])
            put_vector(r, pick_q824(), pick_q824());
      end
   endtask

   // register write, only while the block is idle
   task automatic write_csr(input logic [rmcv_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rmcv_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == rmcv_pkg::CSR_SIZE_IN_USE)
         gen_size = active_size(data[rmcv_pkg::SIZE_W-1:0]);
      @(negedge clock);
   endtask

   // every queued word taken, every result seen, then a short settle
   task automatic wait_idle();
      do
         @(negedge clock);
      while (accepted_count != queued_count || row_sum_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly loads-then-run sequences, with some stray words mixed in
   task automatic random_burst(input int budget);
      int used;
      int kind;
      int loads;
      used = 0;
      while (used < budget) begin
         kind = $urandom_range(9);
         if (kind < 7) begin
            loads = $urandom_range(4);
            repeat (loads) begin
               if ($urandom_range(1))
                  put_matrix($urandom_range(gen_size - 1), $urandom_range(gen_size - 1),
                             pick_q824());
               else
                  put_vector($urandom_range(gen_size - 1), pick_q824(), pick_q824());
            end
            fill_missing(gen_size);
            put_func(rmcv_pkg::FUNC_RUN);
            used += loads + 1;
         end else if (kind == 7) begin
            put_func(FUNC_NOP);
            used++;
         end else begin
            // anywhere in the stores, often past the size in use
            if ($urandom_range(1))
               put_matrix($urandom_range(DIM - 1), $urandom_range(DIM - 1), pick_q824());
            else
               put_vector($urandom_range(DIM - 1), pick_q824(), pick_q824());
            used++;
         end
      end
   endtask

   // --------------------------------------------------------------------
   // test sequence
   // --------------------------------------------------------------------
   initial begin : stimulus
      int size_word;
      logic [rmcv_pkg::CSR_DATA_W-1:0] word;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 38;

      // small forward run with corner operands
      write_csr(rmcv_pkg::CSR_SIZE_IN_USE, 32'd4);
      write_csr(rmcv_pkg::CSR_TRANSPOSE_MODE, 32'd0);
      put_matrix(0, 0, 32'h7fff_ffff);
      put_matrix(0, 1, 32'h8000_0000);
      put_matrix(1, 0, 32'hffff_ffff);
      put_matrix(1, 1, 32'h0100_0000);
      put_matrix(2, 3, 32'h0000_0000);
      put_vector(0, 32'h7fff_ffff, 32'h8000_0000);
      // most negative squared, the largest single product
      put_vector(1, 32'h8000_0000, 32'h8000_0000);
      // tiny values that floor toward minus infinity
      put_vector(2, 32'hffff_ffff, 32'h0000_0001);
      // stored past the size in use, never read by the run
      put_matrix(DIM - 1, DIM - 1, 32'h8000_0000);
      put_vector(DIM - 1, 32'h7fff_ffff, 32'hffff_ffff);
      put_func(FUNC_NOP);
      fill_missing(gen_size);
      put_func(rmcv_pkg::FUNC_RUN);
      wait_idle();

      // same data through the transposed matrix, upper bits of the word set
      write_csr(rmcv_pkg::CSR_TRANSPOSE_MODE, 32'hffff_ffff);
      put_func(rmcv_pkg::FUNC_RUN);
      wait_idle();

      // size field zero acts as one
      write_csr(rmcv_pkg::CSR_SIZE_IN_USE, 32'hffff_ff80);
      put_func(rmcv_pkg::FUNC_RUN);
      wait_idle();

      // write to an empty register index must change nothing
      write_csr(CSR_UNUSED, $urandom);
      put_func(FUNC_NOP);
      put_func(rmcv_pkg::FUNC_RUN);

      // random phases: sender idles 38%, then 49%, then never
      for (int p = 0; p < 12; p++) begin
         wait_idle();
         send_idle_pct = (p < 4) ? 38 : (p < 8) ? 49 : 0;
         if (p == 5 || p == 10)
            size_word = MAX_RAND_SIZE;
         else if ($urandom_range(3) == 0)
            size_word = $urandom_range(MAX_RAND_SIZE);
         else
            size_word = $urandom_range(MAX_RAND_SIZE, 1);
         word = $urandom;
         word[rmcv_pkg::SIZE_W-1:0] = size_word[rmcv_pkg::SIZE_W-1:0];
         write_csr(rmcv_pkg::CSR_SIZE_IN_USE, word);
         word = $urandom;
         // largest random size is forced in one phase each way
         if (p == 5)
            word[0] = 1'b0;
         if (p == 10)
            word[0] = 1'b1;
         write_csr(rmcv_pkg::CSR_TRANSPOSE_MODE, word);
         random_burst(8);
      end

      wait_idle();
      if (fail_count == 0 && row_sum_queue.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* sim.f */
hdl/rmcv_pkg.sv
hdl/rmcv_ram.sv
hdl/rmcv_sequencer.sv
hdl/rmcv_mac.sv
hdl/real_matrix_complex_vector_multiply.sv
tb/tb_top.sv
